@@ hw/rtl/spdl_pkg.sv @@
// ----------------------------------------------------------------------------
// spdl_pkg
// Shared types and constants for the steering PD position loop.
// ----------------------------------------------------------------------------
`default_nettype none

package spdl_pkg;

  // fixed number formats
  localparam int ENCODER_BITS = 12;
  localparam int FRAC_BITS    = 8;

  // parameter defaults
  localparam int MAX_ANGLE_Q8_DEF       = 7680;
  localparam int DUTY_MIN_EFFECTIVE_DEF = 300;

  // field widths
  localparam int OFF_W   = ENCODER_BITS + 1;
  localparam int ANG_W   = 16;
  localparam int ERR_W   = 17;
  localparam int DIF_W   = 18;
  localparam int GAIN_W  = 16;
  localparam int DB_W    = 12;
  localparam int DUTY_W  = 14;

  // shared multiply-accumulate unit
  localparam int MUL_A_W = DIF_W;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + FRAC_BITS;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HOME_POSITION  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SCALE     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SCALE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN      = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_DEADBAND = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX       = 8'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFFSET,
    ST_ANGLE,
    ST_ERROR,
    ST_PROP,
    ST_DERIV,
    ST_GYRO,
    ST_SUM,
    ST_ABS,
    ST_LIMIT
  } state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_SHL
  } acc_sel_t;

  typedef struct packed {
    logic     mul_en;
    acc_sel_t acc_sel;
  } mac_op_t;

endpackage

`default_nettype wire

@@ hw/rtl/steering_pd_position_loop.sv @@
// ----------------------------------------------------------------------------
// steering_pd_position_loop
// PD steering position loop with gyro feedforward, Q8.8 fixed point.
// ----------------------------------------------------------------------------
// One transaction in gives one result: the wrapped encoder offset, the measured
// angle, the clamped target error, and a direction/duty pair from the PD term
// plus gyro feedforward, zeroed inside the deadband, limited to duty_max and
// raised to the minimum effective duty. From accept, each item passes through
// nine sequencer steps (OFFSET to LIMIT) to its result; a single shared
// multiplier-accumulator handles the angle scaling and the three drive terms
// in turn, and in_stall stays high until the result is loaded into the output
// register. That register frees the sequencer as soon as the result is
// written, so a stalled result only delays the next item when it is still
// held when the following one finishes. Configuration writes are taken at any
// time (cfg_ready is always high) but should only be issued while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module steering_pd_position_loop
  import spdl_pkg::*;
#(
  parameter int MAX_ANGLE_Q8       = MAX_ANGLE_Q8_DEF,
  parameter int DUTY_MIN_EFFECTIVE = DUTY_MIN_EFFECTIVE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ENCODER_BITS-1:0]      in_encoder_raw,
  input  logic signed [15:0]           in_gyro_rate,
  input  logic signed [ANG_W-1:0]      in_target_angle,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_direction,
  output logic [DUTY_W-1:0]            out_duty,
  output logic signed [ANG_W-1:0]      out_current_angle,
  output logic signed [ERR_W-1:0]      out_angle_error,
  output logic signed [OFF_W-1:0]      out_home_offset,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam logic signed [ANG_W-1:0] MAX_A = ANG_W'(MAX_ANGLE_Q8);
  localparam logic signed [ANG_W-1:0] MIN_A = -MAX_A;
  localparam logic [DUTY_W-1:0]       DMIN  = DUTY_W'(DUTY_MIN_EFFECTIVE);
  localparam logic [ACC_W-1:0]        DMIN_FULL =
    ACC_W'(DUTY_MIN_EFFECTIVE) << (2 * FRAC_BITS);
  localparam logic signed [ENCODER_BITS+1:0] FULL_S =
    (ENCODER_BITS+2)'(1) << ENCODER_BITS;
  localparam logic signed [ENCODER_BITS+1:0] HALF_S =
    (ENCODER_BITS+2)'(1) << (ENCODER_BITS - 1);
  localparam logic signed [ANG_W-1:0] ANG_POS_MAX = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic signed [ANG_W-1:0] ANG_NEG_MAX = {1'b1, {(ANG_W-1){1'b0}}};
  localparam int MAG_W = PROD_W - FRAC_BITS;

  // configuration
  logic [ENCODER_BITS-1:0] home_r;
  logic [GAIN_W-1:0]       lscale_r, rscale_r, pgain_r, dgain_r;
  logic signed [GAIN_W-1:0] ggain_r;
  logic [DB_W-1:0]         db_r;
  logic [DUTY_W-1:0]       dmax_r;

  // sequencer and kept state
  state_t                  state_r, state_nxt;
  logic signed [DIF_W-1:0] prev_r, prev_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // working registers
  logic [ENCODER_BITS-1:0] raw_r;
  logic signed [15:0]      gyro_r;
  logic signed [ANG_W-1:0] tgt_r, tgt_nxt;
  logic signed [OFF_W-1:0] d_r;
  logic signed [ANG_W-1:0] cur_r;
  logic signed [ERR_W-1:0] err_r;
  logic signed [DIF_W-1:0] dif_r;
  logic                    in_db_r;
  logic                    dir_r;
  logic [ACC_W-1:0]        mag_r;

  // output register payload
  logic                    o_dir_r;
  logic [DUTY_W-1:0]       o_duty_r;
  logic signed [ANG_W-1:0] o_cur_r;
  logic signed [ERR_W-1:0] o_err_r;
  logic signed [OFF_W-1:0] o_off_r;

  // datapath
  logic                    in_acc, out_write;
  mac_op_t                 mac_op;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  logic signed [ENCODER_BITS+1:0] diff_w, wrap_w;
  logic signed [OFF_W-1:0]  ad_w;
  logic [MAG_W-1:0]         amag_w, aneg_w;
  logic signed [ANG_W-1:0]  cur_w;
  logic signed [ERR_W-1:0]  err_w;
  logic signed [DIF_W-1:0]  err_ext, err_abs;
  logic [ACC_W-1:0]         dmax_full;
  logic                     dir_w;
  logic [DUTY_W-1:0]        duty_w;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  spdl_mac u_mac (
    .clk   (clk),
    .op    (mac_op),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod),
    .acc   (acc)
  );

  // target clamp at accept
  always_comb begin
    priority if (in_target_angle > MAX_A) tgt_nxt = MAX_A;
    else if (in_target_angle < MIN_A)     tgt_nxt = MIN_A;
    else                                  tgt_nxt = in_target_angle;
  end

  // offset wrap by half a turn
  always_comb begin
    diff_w = signed'({2'b00, raw_r}) - signed'({2'b00, home_r});
    priority if (diff_w > HALF_S) wrap_w = diff_w - FULL_S;
    else if (diff_w < -HALF_S)    wrap_w = diff_w + FULL_S;
    else                          wrap_w = diff_w;
  end

  // angle from scaled magnitude, then error
  always_comb begin
    ad_w   = d_r[OFF_W-1] ? -d_r : d_r;
    amag_w = prod[PROD_W-1:FRAC_BITS];
    aneg_w = '0 - amag_w;
    if (!d_r[OFF_W-1]) begin
      cur_w = (amag_w > MAG_W'(32768)) ? ANG_NEG_MAX : signed'(aneg_w[ANG_W-1:0]);
    end else begin
      cur_w = (amag_w > MAG_W'(32767)) ? ANG_POS_MAX : signed'(amag_w[ANG_W-1:0]);
    end
    err_w   = {cur_w[ANG_W-1], cur_w};
    err_w   = {tgt_r[ANG_W-1], tgt_r} - err_w;
    err_ext = {err_r[ERR_W-1], err_r};
    err_abs = err_ext[DIF_W-1] ? -err_ext : err_ext;
  end

  // duty limits
  always_comb begin
    dmax_full = ACC_W'(dmax_r) << (2 * FRAC_BITS);
    dir_w     = dir_r;
    if (in_db_r) begin
      dir_w  = 1'b0;
      duty_w = '0;
    end else if (mag_r > dmax_full) begin
      duty_w = (dmax_r < DMIN) ? DMIN : dmax_r;
    end else if (mag_r < DMIN_FULL) begin
      duty_w = DMIN;
    end else begin
      duty_w = mag_r[2*FRAC_BITS+DUTY_W-1:2*FRAC_BITS];
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    mac_op.mul_en  = 1'b0;
    mac_op.acc_sel = ACC_HOLD;
    mul_a          = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
    mul_b          = {1'b0, pgain_r};
    out_write      = 1'b0;
    prev_nxt       = prev_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_OFFSET;
      end
      ST_OFFSET: state_nxt = ST_ANGLE;
      ST_ANGLE: begin
        mac_op.mul_en = 1'b1;
        mul_a = {{(MUL_A_W-OFF_W){1'b0}}, ad_w};
        mul_b = {1'b0, d_r[OFF_W-1] ? rscale_r : lscale_r};
        state_nxt = ST_ERROR;
      end
      ST_ERROR: state_nxt = ST_PROP;
      ST_PROP: begin
        mac_op.mul_en = 1'b1;
        prev_nxt  = err_ext;
        state_nxt = ST_DERIV;
      end
      ST_DERIV: begin
        mac_op.mul_en  = 1'b1;
        mac_op.acc_sel = ACC_LOAD;
        mul_a = dif_r;
        mul_b = {1'b0, dgain_r};
        state_nxt = ST_GYRO;
      end
      ST_GYRO: begin
        mac_op.mul_en  = 1'b1;
        mac_op.acc_sel = ACC_ADD;
        mul_a = {{(MUL_A_W-16){gyro_r[15]}}, gyro_r};
        mul_b = {ggain_r[GAIN_W-1], ggain_r};
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        mac_op.acc_sel = ACC_ADD_SHL;
        state_nxt = ST_ABS;
      end
      ST_ABS: state_nxt = ST_LIMIT;
      ST_LIMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_write = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_write)       out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      home_r      <= ENCODER_BITS'(710);
      lscale_r    <= GAIN_W'(2054);
      rscale_r    <= GAIN_W'(1710);
      pgain_r     <= GAIN_W'(2560);
      dgain_r     <= GAIN_W'(256);
      ggain_r     <= '0;
      db_r        <= DB_W'(128);
      dmax_r      <= DUTY_W'(5000);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_HOME_POSITION:  home_r   <= cfg_data[ENCODER_BITS-1:0];
          CFG_LEFT_SCALE:     lscale_r <= cfg_data[GAIN_W-1:0];
          CFG_RIGHT_SCALE:    rscale_r <= cfg_data[GAIN_W-1:0];
          CFG_PROP_GAIN:      pgain_r  <= cfg_data[GAIN_W-1:0];
          CFG_DERIV_GAIN:     dgain_r  <= cfg_data[GAIN_W-1:0];
          CFG_GYRO_GAIN:      ggain_r  <= signed'(cfg_data[GAIN_W-1:0]);
          CFG_ERROR_DEADBAND: db_r     <= cfg_data[DB_W-1:0];
          CFG_DUTY_MAX:       dmax_r   <= cfg_data[DUTY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      raw_r  <= in_encoder_raw;
      gyro_r <= in_gyro_rate;
      tgt_r  <= tgt_nxt;
    end
    if (state_r == ST_OFFSET) d_r <= wrap_w[OFF_W-1:0];
    if (state_r == ST_ERROR) begin
      cur_r <= cur_w;
      err_r <= err_w;
    end
    if (state_r == ST_PROP) begin
      dif_r   <= err_ext - prev_r;
      in_db_r <= (err_abs <= signed'({{(DIF_W-DB_W){1'b0}}, db_r}));
    end
    if (state_r == ST_ABS) begin
      dir_r <= acc[ACC_W-1];
      mag_r <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    end
    if (out_write) begin
      o_dir_r  <= dir_w;
      o_duty_r <= duty_w;
      o_cur_r  <= cur_r;
      o_err_r  <= err_r;
      o_off_r  <= d_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_direction     = o_dir_r;
  assign out_duty          = o_duty_r;
  assign out_current_angle = o_cur_r;
  assign out_angle_error   = o_err_r;
  assign out_home_offset   = o_off_r;

endmodule

`default_nettype wire

@@ hw/rtl/spdl_mac.sv @@
// ----------------------------------------------------------------------------
// spdl_mac
// Shared signed multiplier with registered product and a wide accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module spdl_mac
  import spdl_pkg::*;
(
  input  logic                      clk,
  input  mac_op_t                   op,
  input  logic signed [MUL_A_W-1:0] mul_a,
  input  logic signed [MUL_B_W-1:0] mul_b,
  output logic signed [PROD_W-1:0]  prod,
  output logic signed [ACC_W-1:0]   acc
);

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_comb begin
    prod_nxt = op.mul_en ? mul_a * mul_b : prod_r;
    unique case (op.acc_sel)
      ACC_HOLD:    acc_nxt = acc_r;
      ACC_LOAD:    acc_nxt = prod_ext;
      ACC_ADD:     acc_nxt = acc_r + prod_ext;
      ACC_ADD_SHL: acc_nxt = acc_r + (prod_ext <<< FRAC_BITS);
      default:     acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

`default_nettype wire

@@ hw/rtl/spdl_checker.sv @@
// ----------------------------------------------------------------------------
// spdl_checker
// Port-level checks for the steering PD position loop, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spdl_checker
  import spdl_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [DUTY_W-1:0]    out_duty,
  input wire logic                 out_direction
);

  // a result held under stall keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty) && $stable(out_direction))
    else $error("stalled result changed");

  // after a transaction is taken the block is busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a result never appears the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // a new result is only produced by the busy sequencer
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work in progress");

endmodule

bind steering_pd_position_loop spdl_checker u_spdl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_duty      (out_duty),
  .out_direction (out_direction)
);

`default_nettype wire
